>>> src/top_k_smallest_selector_top_defines.svh
// ----------------------------------------------------------------------------
// top-k selector assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TOP_K_SMALLEST_SELECTOR_TOP_DEFINES_SVH
`define TOP_K_SMALLEST_SELECTOR_TOP_DEFINES_SVH

// same-cycle implication
`define TKS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("top-k selector check failed");

// next-cycle implication
`define TKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("top-k selector check failed");

`endif

>>> src/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// types and constants shared by the top-k selector modules
// ----------------------------------------------------------------------------
package tks_pkg;

   localparam int K_MAX_DEFAULT = 16;
   localparam int DIST_W        = 32;
   localparam int ID_W          = 64;
   localparam int KCFG_W        = 5;
   localparam int POS_W         = 4;

   localparam logic [KCFG_W-1:0] K_RESET = 5'd16;

   typedef logic signed [DIST_W-1:0] dist_type;
   typedef logic [ID_W-1:0]          id_type;

   typedef struct packed {
      logic insert;
      logic rotate;
      logic occupied;
      logic tail;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

endpackage

>>> src/top_k_smallest_selector_top.sv
// ----------------------------------------------------------------------------
// top_k_smallest_selector_top
// keeps the k smallest (distance, id) pairs of a query and emits them sorted
// ----------------------------------------------------------------------------
// Candidates enter one item per clock while the block is idle: a row of
// K_MAX cells compares the new distance against every held entry at once and
// slides larger entries up one slot in the same cycle. An item marked last
// then holds req_ready low while the held entries (1 to k of them) are read
// out through cell 0, one per cycle while rsp_ready allows, as the row rotates
// left around the filled slots. The list stays intact after readout. Slot
// storage has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module top_k_smallest_selector_top import tks_pkg::*; #(
   parameter int K_MAX = K_MAX_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [KCFG_W-1:0] csr_k_in_use,
   input  logic              req_valid,
   output logic              req_ready,
   input  dist_type          req_cand_distance,
   input  id_type            req_cand_id,
   input  logic              req_first_of_query,
   input  logic              req_last_of_query,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output id_type            rsp_rank_id,
   output dist_type          rsp_rank_distance,
   output logic [POS_W-1:0]  rsp_rank_position,
   output logic              rsp_last_of_list
);

   localparam int FILL_W = $clog2(K_MAX + 1);

   logic [KCFG_W-1:0] k_cfg_ff;
   logic [FILL_W-1:0] k_eff;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [FILL_W-1:0] fill_eff;
   logic [FILL_W-1:0] cnt_ff;
   logic [FILL_W-1:0] cnt_in;
   state_type         state_ff;
   state_type         state_in;
   logic              accept;
   logic              load;
   logic              last_rank;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   id_type            rsp_id_ff;
   dist_type          rsp_dist_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic              rsp_last_ff;

   dist_type     cell_dist [K_MAX];
   id_type       cell_id   [K_MAX];
   logic         cell_lt   [K_MAX];
   cell_ctl_type cell_ctl  [K_MAX];

   always_comb begin
      if (k_cfg_ff == '0) begin
         k_eff = FILL_W'(1);
      end else if (int'(k_cfg_ff) > K_MAX) begin
         k_eff = FILL_W'(K_MAX);
      end else begin
         k_eff = FILL_W'(k_cfg_ff);
      end
   end

   // list cleared by a first item, truncated when k was lowered
   always_comb begin
      if (req_first_of_query) begin
         fill_eff = '0;
      end else if (fill_ff > k_eff) begin
         fill_eff = k_eff;
      end else begin
         fill_eff = fill_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign load      = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign last_rank = (cnt_ff + FILL_W'(1)) == fill_ff;

   always_comb begin
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fill_in = (fill_eff < k_eff) ? fill_eff + FILL_W'(1) : fill_eff;
               cnt_in  = '0;
               if (req_last_of_query) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               cnt_in       = cnt_ff + FILL_W'(1);
               if (last_rank) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_cfg_ff     <= K_RESET;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            k_cfg_ff <= csr_k_in_use;
         end
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_id_ff   <= cell_id[0];
         rsp_dist_ff <= cell_dist[0];
         rsp_pos_ff  <= POS_W'(cnt_ff);
         rsp_last_ff <= last_rank;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < K_MAX; gi++) begin : g_cell
         dist_type left_dist;
         id_type   left_id;
         logic     left_lt;
         dist_type right_dist;
         id_type   right_id;

         if (gi == 0) begin : g_head
            assign left_dist = req_cand_distance;
            assign left_id   = req_cand_id;
            assign left_lt   = 1'b0;
         end else begin : g_body
            assign left_dist = cell_dist[gi-1];
            assign left_id   = cell_id[gi-1];
            assign left_lt   = cell_lt[gi-1];
         end

         if (gi == K_MAX - 1) begin : g_end
            assign right_dist = cell_dist[0];
            assign right_id   = cell_id[0];
         end else begin : g_mid
            assign right_dist = cell_dist[gi+1];
            assign right_id   = cell_id[gi+1];
         end

         assign cell_ctl[gi].insert   = accept;
         assign cell_ctl[gi].rotate   = load;
         assign cell_ctl[gi].occupied = FILL_W'(gi) < fill_eff;
         assign cell_ctl[gi].tail     = FILL_W'(gi) == (fill_ff - FILL_W'(1));

         tks_cell u_cell (
            .clock          (clock),
            .ctl            (cell_ctl[gi]),
            .cand_distance  (req_cand_distance),
            .cand_id        (req_cand_id),
            .left_distance  (left_dist),
            .left_id        (left_id),
            .left_lt        (left_lt),
            .right_distance (right_dist),
            .right_id       (right_id),
            .head_distance  (cell_dist[0]),
            .head_id        (cell_id[0]),
            .distance       (cell_dist[gi]),
            .id             (cell_id[gi]),
            .lt             (cell_lt[gi])
         );
      end
   endgenerate

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rank_id       = rsp_id_ff;
   assign rsp_rank_distance = rsp_dist_ff;
   assign rsp_rank_position = rsp_pos_ff;
   assign rsp_last_of_list  = rsp_last_ff;

endmodule

>>> src/tks_cell.sv
// ----------------------------------------------------------------------------
// tks_cell
// one slot of the sorted list: parallel insert and rotate-left for readout
// ----------------------------------------------------------------------------
module tks_cell import tks_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  dist_type     cand_distance,
   input  id_type       cand_id,
   input  dist_type     left_distance,
   input  id_type       left_id,
   input  logic         left_lt,
   input  dist_type     right_distance,
   input  id_type       right_id,
   input  dist_type     head_distance,
   input  id_type       head_id,
   output dist_type     distance,
   output id_type       id,
   output logic         lt
);

   dist_type dist_ff;
   dist_type dist_in;
   id_type   id_ff;
   id_type   id_in;

   // empty slots count as larger than any candidate
   assign lt = !ctl.occupied || (cand_distance < dist_ff);

   always_comb begin
      dist_in = dist_ff;
      id_in   = id_ff;
      if (ctl.insert && lt) begin
         if (left_lt) begin
            dist_in = left_distance;
            id_in   = left_id;
         end else begin
            dist_in = cand_distance;
            id_in   = cand_id;
         end
      end else if (ctl.rotate) begin
         if (ctl.tail) begin
            dist_in = head_distance;
            id_in   = head_id;
         end else begin
            dist_in = right_distance;
            id_in   = right_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      id_ff   <= id_in;
   end

   assign distance = dist_ff;
   assign id       = id_ff;

endmodule

>>> src/tks_checker.sv
// ----------------------------------------------------------------------------
// tks_checker
// port-level checks on the top-k selector, bound to the top level
// ----------------------------------------------------------------------------
`include "top_k_smallest_selector_top_defines.svh"

module tks_checker import tks_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input id_type            rsp_rank_id,
   input dist_type          rsp_rank_distance,
   input logic [POS_W-1:0]  rsp_rank_position,
   input logic              rsp_last_of_list
);

   logic                       rsp_take;
   logic                       rsp_more;
   logic                       rsp_stall;
   logic [ID_W+DIST_W+POS_W:0] rsp_payload;
   logic [POS_W-1:0]           pos_next_ff;
   logic [POS_W-1:0]           pos_next_in;
   dist_type                   dist_prev_ff;
   dist_type                   dist_prev_in;
   logic                       rsp_step_ok;
   logic                       rsp_order_ok;

   assign rsp_take     = rsp_valid && rsp_ready;
   assign rsp_more     = rsp_take && !rsp_last_of_list;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_payload  = {rsp_rank_id, rsp_rank_distance, rsp_rank_position, rsp_last_of_list};
   assign pos_next_in  = rsp_rank_position + POS_W'(1);
   assign dist_prev_in = rsp_rank_distance;

   always_ff @(posedge clock) begin
      pos_next_ff  <= pos_next_in;
      dist_prev_ff <= dist_prev_in;
   end

   assign rsp_step_ok  = rsp_valid && (rsp_rank_position == pos_next_ff);
   assign rsp_order_ok = rsp_rank_distance >= dist_prev_ff;

   // stalled item holds
   `TKS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // ranks of one list follow back to back
   `TKS_ASSERT_NEXT(a_rank_step, clock, reset, rsp_more, rsp_step_ok)

   // list comes out best first
   `TKS_ASSERT_NEXT(a_rank_order, clock, reset, rsp_more, rsp_order_ok)

   // no new item while a list is still being read out
   `TKS_ASSERT_NOW(a_busy_emit, clock, reset, rsp_valid && !rsp_last_of_list, !req_ready)

endmodule

bind top_k_smallest_selector_top tks_checker u_tks_checker (.*);
